// ----- hdl/aesbe_pkg.sv -----
package aesbe_pkg;

	// Fixed sizes of the cipher.
	localparam int ROUND_KEY_WORDS = 60;
	localparam int MAX_ROUNDS      = 14;
	localparam logic [7:0] RCON_FIRST = 8'h01;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_KEY_SIZE   = 3'd0,
		REG_KEY_PART_0 = 3'd1,
		REG_KEY_PART_1 = 3'd2,
		REG_KEY_PART_2 = 3'd3,
		REG_KEY_PART_3 = 3'd4
	} cfg_reg_t;

	// Key size codes.
	localparam logic [1:0] KEY_128 = 2'd0;
	localparam logic [1:0] KEY_192 = 2'd1;

	// One configuration write.
	typedef struct packed {
		logic        we;
		logic [2:0]  index;
		logic [63:0] wdata;
	} cfg_wr_t;

	// What a round cell does with its word.
	typedef struct packed {
		logic pass;
		logic last;
	} cell_mode_t;

	typedef logic [ROUND_KEY_WORDS-1:0][31:0] rk_array_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	// Multiplication by two in the AES field.
	function automatic logic [7:0] gf_double(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	// S-box applied to each byte of a word.
	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

endpackage

// ----- hdl/aesbe_if.sv -----
// Plaintext channel.
interface aesbe_pt_if;
	logic        valid;
	logic        ready;
	logic [63:0] plaintext_high;
	logic [63:0] plaintext_low;
	modport source (output valid, output plaintext_high, output plaintext_low, input ready);
	modport sink (input valid, input plaintext_high, input plaintext_low, output ready);
endinterface

// Ciphertext channel.
interface aesbe_ct_if;
	logic        valid;
	logic        ready;
	logic [63:0] ciphertext_high;
	logic [63:0] ciphertext_low;
	modport source (output valid, output ciphertext_high, output ciphertext_low, input ready);
	modport sink (input valid, input ciphertext_high, input ciphertext_low, output ready);
endinterface

// ----- hdl/aesbe_key_exp.sv -----
module aesbe_key_exp
	import aesbe_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_wr_t    cfg,
	output logic       busy,
	output logic [3:0] rounds,
	output rk_array_t  round_keys
);

	logic [1:0]  key_size_q;
	logic [63:0] key_part_q [4];
	logic        busy_q;
	logic [5:0]  idx_q;
	logic [2:0]  mod_q;
	logic [7:0]  rc_q;
	logic [31:0] win_q [8];
	rk_array_t   rk_q;

	logic [3:0]  nk;
	logic [5:0]  total;
	logic [31:0] key_word;
	logic [31:0] far_word;
	logic [31:0] tmp;
	logic [31:0] new_word;
	logic        done;

	// Configuration registers; any write restarts the expansion.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_size_q <= KEY_128;
			for (int k = 0; k < 4; k++) key_part_q[k] <= '0;
		end else if (cfg.we) begin
			unique case (cfg.index)
				REG_KEY_SIZE:   key_size_q    <= cfg.wdata[1:0];
				REG_KEY_PART_0: key_part_q[0] <= cfg.wdata;
				REG_KEY_PART_1: key_part_q[1] <= cfg.wdata;
				REG_KEY_PART_2: key_part_q[2] <= cfg.wdata;
				REG_KEY_PART_3: key_part_q[3] <= cfg.wdata;
				default: ;
			endcase
		end
	end

	// Key length in words and round count.
	always_comb begin
		unique case (key_size_q)
			KEY_128: nk = 4'd4;
			KEY_192: nk = 4'd6;
			default: nk = 4'd8;
		endcase
		rounds = nk + 4'd6;
		total  = {rounds + 4'd1, 2'b00};
		done   = (idx_q == total - 6'd1);
	end

	// Next schedule word.
	always_comb begin
		key_word = idx_q[0] ? key_part_q[idx_q[2:1]][31:0] : key_part_q[idx_q[2:1]][63:32];
		unique case (key_size_q)
			KEY_128: far_word = win_q[3];
			KEY_192: far_word = win_q[5];
			default: far_word = win_q[7];
		endcase
		tmp = win_q[0];
		if (mod_q == 3'd0) begin
			tmp = sub_word({win_q[0][23:0], win_q[0][31:24]}) ^ {rc_q, 24'h0};
		end else if (nk == 4'd8 && mod_q == 3'd4) begin
			tmp = sub_word(win_q[0]);
		end
		new_word = ({2'b00, idx_q} < {4'h0, nk}) ? key_word : (far_word ^ tmp);
	end

	// Expansion sequencer, one word a cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
			mod_q  <= '0;
			rc_q   <= RCON_FIRST;
		end else if (cfg.we) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
			mod_q  <= '0;
			rc_q   <= RCON_FIRST;
		end else if (busy_q) begin
			idx_q  <= idx_q + 6'd1;
			mod_q  <= ({1'b0, mod_q} == nk - 4'd1) ? 3'd0 : mod_q + 3'd1;
			if (mod_q == 3'd0 && {2'b00, idx_q} >= {4'h0, nk}) rc_q <= gf_double(rc_q);
			if (done) busy_q <= 1'b0;
		end
	end

	// Sliding window of recent words and the round-key store.
	always_ff @(posedge clk) begin
		if (busy_q && !cfg.we) begin
			win_q[0] <= new_word;
			for (int k = 1; k < 8; k++) win_q[k] <= win_q[k-1];
			rk_q[idx_q] <= new_word;
		end
	end

	assign busy       = busy_q;
	assign round_keys = rk_q;

endmodule

// ----- hdl/aesbe_round_cell.sv -----
module aesbe_round_cell
	import aesbe_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  cell_mode_t   mode,
	input  logic         valid_in,
	input  logic [127:0] state_in,
	input  logic [127:0] round_key,
	output logic         valid_out,
	output logic [127:0] state_out
);

	logic         valid_q;
	logic [127:0] state_q;
	logic [127:0] next_state;

	// SubBytes, ShiftRows, optional MixColumns and the key addition, or a plain pass-through in pass mode.
	always_comb begin
		logic [7:0] b [4];
		logic [7:0] m [4];
		logic [7:0] all;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				b[r] = SBOX[state_in[127 - 32*((c + r) % 4) - 8*r -: 8]];
			end
			all = b[0] ^ b[1] ^ b[2] ^ b[3];
			for (int r = 0; r < 4; r++) begin
				m[r] = mode.last ? b[r] : (b[r] ^ all ^ gf_double(b[r] ^ b[(r + 1) % 4]));
			end
			next_state[127 - 32*c -: 32] = {m[0], m[1], m[2], m[3]} ^ round_key[127 - 32*c -: 32];
		end
		if (mode.pass) next_state = state_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) state_q <= next_state;
	end

	assign valid_out = valid_q;
	assign state_out = state_q;

endmodule

// ----- hdl/aes_block_encrypt.sv -----
// AES block encryption, 128-, 192- or 256-bit key.
// Configuration: cfg_we with cfg_index and cfg_wdata writes key_size (index 0)
// and the four 64-bit key parts (indexes 1 to 4). Each write, and reset, starts
// the round-key expansion, one word a cycle: 44, 52 or 60 words for 128-, 192-
// and 256-bit keys. pt.ready stays low until it is done.
// Channels: pt takes one plaintext word (two 64-bit halves) a cycle when
// pt.valid and pt.ready are high; ct delivers the ciphertext word likewise.
// Path: the key-addition register loads at the accepting edge and each of the
// fourteen round cells adds one register, the same for all key sizes; ct.valid
// comes from the last cell. Rounds past the last one for the key size pass the
// word through unchanged.
// Throughput: one word a cycle while ct is taken and no key expansion runs.
// When the receiver stalls, the whole row of cells holds and pt.ready falls
// only once the last cell holds a word; nothing is lost. Reset empties the row.
module aes_block_encrypt
	import aesbe_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [63:0] cfg_wdata,
	aesbe_pt_if.sink   pt,
	aesbe_ct_if.source ct
);

	cfg_wr_t      cfg;
	logic         busy;
	logic [3:0]   rounds;
	rk_array_t    rk;
	logic         adv;
	logic         accept;
	logic         valid_s0;
	logic [127:0] state_s0;
	logic         cell_valid [MAX_ROUNDS+1];
	logic [127:0] cell_state [MAX_ROUNDS+1];

	assign cfg = '{we: cfg_we, index: cfg_index, wdata: cfg_wdata};

	aesbe_key_exp u_key_exp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.busy       (busy),
		.rounds     (rounds),
		.round_keys (rk)
	);

	// The row moves whenever the last cell is empty or being emptied.
	assign adv      = !cell_valid[MAX_ROUNDS] || ct.ready;
	assign pt.ready = !busy && adv;
	assign accept   = pt.valid && pt.ready;

	// Initial key addition.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s0 <= 1'b0;
		end else if (adv) begin
			valid_s0 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			state_s0 <= {pt.plaintext_high, pt.plaintext_low} ^
				{rk[0], rk[1], rk[2], rk[3]};
		end
	end

	assign cell_valid[0] = valid_s0;
	assign cell_state[0] = state_s0;

	// Row of round cells.
	for (genvar k = 1; k <= MAX_ROUNDS; k++) begin : g_round
		cell_mode_t mode;
		assign mode.pass = (4'(k) > rounds);
		assign mode.last = (4'(k) == rounds);
		aesbe_round_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (adv),
			.mode      (mode),
			.valid_in  (cell_valid[k-1]),
			.state_in  (cell_state[k-1]),
			.round_key ({rk[4*k], rk[4*k+1], rk[4*k+2], rk[4*k+3]}),
			.valid_out (cell_valid[k]),
			.state_out (cell_state[k])
		);
	end

	assign ct.valid           = cell_valid[MAX_ROUNDS];
	assign ct.ciphertext_high = cell_state[MAX_ROUNDS][127:64];
	assign ct.ciphertext_low  = cell_state[MAX_ROUNDS][63:0];

	// No word enters while the key schedule is being built.
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !busy) else $error("word accepted during key expansion");

	// A configuration write always restarts the expansion.
	a_cfg_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> busy) else $error("expansion not restarted by write");

	// A stalled result keeps the row still.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(ct.valid && !ct.ready) |=> $stable(valid_s0) && ct.valid)
		else $error("row moved under a stall");

endmodule
